@@ hdl/bpa_pkg.sv @@
package bpa_pkg;

   // payload widths of the two channels
   localparam int KIND_W   = 2;
   localparam int TYPE_W   = 2;
   localparam int ID_W     = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;

   // request kinds: bit 1 set means restore everything
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam int                KIND_RESET_BIT = 1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_NEW     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_HELD    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_RESET   = 3'd5;

   // commands from the sequencer to the free-slot stacks
   typedef struct packed {
      logic restore;
      logic rd;
      logic pop;
      logic push;
   } stk_ctrl_type;

endpackage

@@ hdl/bpa_req_if.sv @@
interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::KIND_W-1:0]    kind;
   logic [bpa_pkg::TYPE_W-1:0]    buffer_type;
   logic [bpa_pkg::ID_W-1:0]      buffer_id;

   modport source (output valid, output kind, output buffer_type, output buffer_id,
                   input ready);
   modport sink   (input valid, input kind, input buffer_type, input buffer_id,
                   output ready);
endinterface

@@ hdl/bpa_rsp_if.sv @@
interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::SLOT_W-1:0]    slot;
   logic [bpa_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output slot, output status, input ready);
   modport sink   (input valid, input slot, input status, output ready);
endinterface

@@ hdl/bpa_ram.sv @@
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wr_data,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bpa_free_stack.sv @@
module bpa_free_stack #(
   parameter int NUM_TYPES      = 4,
   parameter int SLOTS_PER_TYPE = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  bpa_pkg::stk_ctrl_type                          ctrl,
   input  logic [((NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1)-1:0] type_sel,
   input  logic [$clog2(SLOTS_PER_TYPE)-1:0]              push_slot,
   output logic [$clog2(SLOTS_PER_TYPE+1)-1:0]            sel_count,
   output logic [$clog2(SLOTS_PER_TYPE)-1:0]              front_slot
);

   localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int PW = $clog2(SLOTS_PER_TYPE);
   localparam int CW = $clog2(SLOTS_PER_TYPE + 1);
   localparam int TN = 1 << TW;

   // front of the queue is the top of the stack at position count-1;
   // positions below the low-water mark read as their reset value, not from the ram
   logic [CW-1:0] count_ff [TN];
   logic [CW-1:0] count_in [TN];
   logic [CW-1:0] lw_ff [TN];
   logic [CW-1:0] lw_in [TN];
   logic [PW-1:0] pos_ff, pos_in;
   logic [TW-1:0] pt_ff, pt_in;
   logic          written_ff, written_in;
   logic [PW-1:0] rd_pos;
   logic [PW-1:0] ram_q;

   assign rd_pos    = PW'(count_ff[type_sel] - 1'b1);
   assign sel_count = count_ff[type_sel];

   always_comb begin
      count_in   = count_ff;
      lw_in      = lw_ff;
      pos_in     = pos_ff;
      pt_in      = pt_ff;
      written_in = written_ff;
      if (ctrl.restore) begin
         for (int t = 0; t < TN; t++) begin
            count_in[t] = CW'(SLOTS_PER_TYPE);
            lw_in[t]    = CW'(SLOTS_PER_TYPE);
         end
      end
      if (ctrl.rd) begin
         pos_in     = rd_pos;
         pt_in      = type_sel;
         written_in = (CW'(rd_pos) >= lw_ff[type_sel]);
      end
      if (ctrl.pop) begin
         count_in[pt_ff] = CW'(pos_ff);
         if (CW'(pos_ff) < lw_ff[pt_ff]) begin
            lw_in[pt_ff] = CW'(pos_ff);
         end
      end
      if (ctrl.push) begin
         count_in[type_sel] = count_ff[type_sel] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TN; t++) begin
            count_ff[t] <= CW'(SLOTS_PER_TYPE);
            lw_ff[t]    <= CW'(SLOTS_PER_TYPE);
         end
      end else begin
         count_ff <= count_in;
         lw_ff    <= lw_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      pt_ff      <= pt_in;
      written_ff <= written_in;
   end

   bpa_ram #(
      .WIDTH (PW),
      .DEPTH (1 << (TW + PW))
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .rd_en   (ctrl.rd),
      .addr    ({type_sel, (ctrl.push ? PW'(count_ff[type_sel]) : rd_pos)}),
      .wr_data (push_slot),
      .rd_data (ram_q)
   );

   assign front_slot = written_ff ? ram_q : (PW'(SLOTS_PER_TYPE - 1) - pos_ff);

endmodule

@@ hdl/binding_point_allocator.sv @@
// sequence: allocate and release latch the request, scan the table one entry read per
// cycle, decide, pop the free queue for a new allocation, then hand over the result;
// a restore goes straight from the request to the hand-over. One request at a time,
// the next is taken once the result is handed over to the response register
// reset (synchronous, active high): all free queues full and in order, table empty
module binding_point_allocator #(
   parameter int NUM_TYPES      = 4,
   parameter int SLOTS_PER_TYPE = 16,
   parameter int MAP_ENTRIES    = 64
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus
);

   localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int PW    = $clog2(SLOTS_PER_TYPE);
   localparam int CW    = $clog2(SLOTS_PER_TYPE + 1);
   localparam int AW    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int NW    = $clog2(MAP_ENTRIES + 1);
   localparam int IdW   = bpa_pkg::ID_W;
   localparam int SlotW = bpa_pkg::SLOT_W;
   localparam int MW    = IdW + PW + TW;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_POP    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [bpa_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [bpa_pkg::TYPE_W-1:0] btype_ff, btype_in;
   logic [IdW-1:0]             id_ff, id_in;

   // table scan bookkeeping
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [PW-1:0] hit_slot_ff, hit_slot_in;
   logic [TW-1:0] hit_type_ff, hit_type_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;

   // per-entry valid bits of the table
   logic [MAP_ENTRIES-1:0] map_valid_ff, map_valid_in;

   // working result and response register
   logic [SlotW-1:0]             res_slot_ff, res_slot_in;
   logic [bpa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SlotW-1:0]             rsp_slot_ff, rsp_slot_in;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // datapath
   logic                  issue;
   logic [AW-1:0]         cnt_idx;
   logic                  map_rd_en, map_wr_en;
   logic [AW-1:0]         map_addr;
   logic [MW-1:0]         map_wr_data, map_rd_data;
   logic [IdW-1:0]        rd_id;
   logic [PW-1:0]         rd_slot;
   logic [TW-1:0]         rd_type;
   logic [2:0]            btype3;
   logic                  is_alloc;
   logic                  req_type_ok, hit_type_ok;
   bpa_pkg::stk_ctrl_type stk;
   logic [TW-1:0]         type_sel;
   logic [CW-1:0]         sel_count;
   logic [PW-1:0]         front_slot;

   // one table entry is read per scan cycle, the compare sees it in the next cycle
   assign issue   = (cnt_ff < NW'(MAP_ENTRIES));
   assign cnt_idx = cnt_ff[AW-1:0];
   assign {rd_id, rd_slot, rd_type} = map_rd_data;

   assign btype3      = {1'b0, btype_ff};
   assign is_alloc    = (kind_ff == bpa_pkg::KIND_ALLOC);
   assign req_type_ok = (int'(btype_ff) < NUM_TYPES);
   assign hit_type_ok = (int'(hit_type_ff) < NUM_TYPES);

   // allocation draws on the requested type, release returns to the stored type
   assign type_sel = is_alloc ? btype3[TW-1:0] : hit_type_ff;

   assign map_rd_en   = (state_ff == ST_SCAN) && issue;
   assign map_wr_en   = (state_ff == ST_POP);
   assign map_addr    = map_wr_en ? free_idx_ff : cnt_idx;
   assign map_wr_data = {id_ff, front_slot, btype3[TW-1:0]};

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      btype_in      = btype_ff;
      id_in         = id_ff;
      cnt_in        = cnt_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_slot_in   = hit_slot_ff;
      hit_type_in   = hit_type_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      map_valid_in  = map_valid_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      stk           = '0;

      // response beat taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               kind_in    = req_bus.kind;
               btype_in   = req_bus.buffer_type;
               id_in      = req_bus.buffer_id;
               cnt_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               if (req_bus.kind[bpa_pkg::KIND_RESET_BIT]) begin
                  // restore all queues and empty the table at once
                  stk.restore   = 1'b1;
                  map_valid_in  = '0;
                  res_slot_in   = '0;
                  res_status_in = bpa_pkg::STATUS_RESET;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               cnt_in     = cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_idx;
               // first empty entry, used by a new allocation
               if (!map_valid_ff[cnt_idx] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cnt_idx;
               end
            end else begin
               state_in = ST_DECIDE;
            end
            // id compare on the entry read last cycle
            if (cmp_vld_ff && map_valid_ff[cmp_idx_ff] && (rd_id == id_ff) && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_slot_in = rd_slot;
               hit_type_in = rd_type;
            end
         end

         ST_DECIDE: begin
            res_slot_in = '0;
            state_in    = ST_DONE;
            if (is_alloc) begin
               if (hit_ff) begin
                  res_slot_in   = SlotW'(hit_slot_ff);
                  res_status_in = bpa_pkg::STATUS_HELD;
               end else if (!req_type_ok || (sel_count == '0) || !free_ff) begin
                  res_status_in = bpa_pkg::STATUS_NONE;
               end else begin
                  // fetch the front of the queue
                  stk.rd   = 1'b1;
                  state_in = ST_POP;
               end
            end else begin
               if (!hit_ff) begin
                  res_status_in = bpa_pkg::STATUS_UNKNOWN;
               end else begin
                  map_valid_in[hit_idx_ff] = 1'b0;
                  // slot back to the front of its own queue, dropped if that is full or its type is out of range
                  if (hit_type_ok && (sel_count < CW'(SLOTS_PER_TYPE))) begin
                     stk.push = 1'b1;
                  end
                  res_slot_in   = SlotW'(hit_slot_ff);
                  res_status_in = bpa_pkg::STATUS_FREED;
               end
            end
         end

         ST_POP: begin
            // front slot is back from the stack ram, record the new binding
            stk.pop                   = 1'b1;
            map_valid_in[free_idx_ff] = 1'b1;
            res_slot_in               = SlotW'(front_slot);
            res_status_in             = bpa_pkg::STATUS_NEW;
            state_in                  = ST_DONE;
         end

         ST_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         map_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         map_valid_ff <= map_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers, always written before use
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      btype_ff      <= btype_in;
      id_ff         <= id_in;
      cnt_ff        <= cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_slot_ff   <= hit_slot_in;
      hit_type_ff   <= hit_type_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // binding table: id, slot and type of each entry
   bpa_ram #(
      .WIDTH (MW),
      .DEPTH (MAP_ENTRIES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .rd_en   (map_rd_en),
      .addr    (map_addr),
      .wr_data (map_wr_data),
      .rd_data (map_rd_data)
   );

   // per-type free queues
   bpa_free_stack #(
      .NUM_TYPES      (NUM_TYPES),
      .SLOTS_PER_TYPE (SLOTS_PER_TYPE)
   ) u_free_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stk),
      .type_sel   (type_sel),
      .push_slot  (hit_slot_ff),
      .sel_count  (sel_count),
      .front_slot (front_slot)
   );

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.slot   = rsp_slot_ff;
   assign rsp_bus.status = rsp_status_ff;

endmodule
